[hw/rtl/asfs_pkg.sv]
`timescale 1ns / 1ps
package asfs_pkg;
   localparam int MaxAttrs = 64;
   localparam int IdxW = 6;
   localparam int CntW = 7;
   localparam int ConfW = 16;
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_PAIR_MODE = 1'b1;
   localparam logic [ConfW-1:0] THRESHOLD_RESET = 16'd32768;

   typedef struct packed {
      logic [IdxW-1:0]  index;
      logic [ConfW-1:0] conf;
      logic             keep;
      logic             drop;
      logic             last;
   } work_type;

   function automatic logic [16:0] sig_entry(input logic [3:0] k);
      case (k)
         4'd0:    sig_entry = 17'd32768;
         4'd1:    sig_entry = 17'd47911;
         4'd2:    sig_entry = 17'd57724;
         4'd3:    sig_entry = 17'd62428;
         4'd4:    sig_entry = 17'd64357;
         4'd5:    sig_entry = 17'd65097;
         4'd6:    sig_entry = 17'd65374;
         4'd7:    sig_entry = 17'd65476;
         4'd8:    sig_entry = 17'd65514;
         4'd9:    sig_entry = 17'd65528;
         4'd10:   sig_entry = 17'd65533;
         default: sig_entry = 17'd65535;
      endcase
   endfunction
endpackage

[hw/rtl/asfs_front.sv]
`timescale 1ns / 1ps
module asfs_front import asfs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic signed [15:0]  logit_neg,
   input  logic signed [15:0]  logit_pos,
   input  logic                last_attr,
   input  logic [ConfW-1:0]    threshold,
   input  logic                pair_mode,
   output logic                out_valid,
   output work_type            out_work
);
   logic [CntW-1:0] next_index_ff, next_index_in;
   logic signed [16:0] x;
   logic [16:0] a;
   logic [3:0] k;
   logic [7:0] f;
   logic [16:0] t0, t1;
   logic [24:0] prod;
   logic [16:0] p, pr;
   logic drop;
   work_type work_ff, work_in;
   logic valid_ff;

   always_comb begin
      x = pair_mode ? (17'(logit_pos) - 17'(logit_neg)) : 17'(logit_neg);
      a = x[16] ? 17'(-x) : 17'(x);
      k = (a[16:8] >= 9'd12) ? 4'd12 : a[11:8];
      f = a[7:0];
      t0 = sig_entry(k);
      t1 = sig_entry(k + 4'd1);
      prod = 25'(t1 - t0) * 25'(f) + 25'd128;
      p = (k == 4'd12) ? 17'd65535 : t0 + 17'(prod[24:8]);
      pr = x[16] ? 17'd65536 - p : p;
      drop = (next_index_ff >= CntW'(MaxAttrs));
      work_in.index = next_index_ff[IdxW-1:0];
      work_in.conf = pr[15:0];
      work_in.keep = !drop && (pr[15:0] > threshold);
      work_in.drop = drop;
      work_in.last = last_attr;
      next_index_in = next_index_ff;
      if (in_valid) begin
         if (last_attr) next_index_in = '0;
         else if (!drop) next_index_in = next_index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         next_index_ff <= next_index_in;
         valid_ff <= in_valid;
      end
      if (in_valid) work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work = work_ff;
endmodule

[hw/rtl/asfs_fifo.sv]
`timescale 1ns / 1ps
module asfs_fifo import asfs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  work_type wr_data,
   input  logic     rd_en,
   output work_type rd_data,
   output logic     empty,
   output logic     almost_full
);
   work_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 3'(wr_en) - 3'(rd_en);
      end
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   assign rd_data = mem_ff[rp_ff];
   assign empty = (cnt_ff == 3'd0);
   assign almost_full = (cnt_ff >= 3'd2);
endmodule

[hw/rtl/asfs_back.sv]
`timescale 1ns / 1ps
module asfs_back import asfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  work_type         q_data,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [IdxW-1:0]  rsp_attr_index,
   output logic [ConfW-1:0] rsp_confidence,
   output logic             rsp_entry_valid,
   output logic             rsp_overflow,
   output logic             rsp_last_result
);
   typedef enum logic [1:0] {
      ST_COLLECT = 2'b01,
      ST_EMIT    = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [IdxW-1:0]  idx_ff [MaxAttrs];
   logic [ConfW-1:0] conf_ff [MaxAttrs];
   logic [CntW-1:0] count_ff, count_in, rd_ff, rd_in;
   logic ovf_ff, ovf_in;
   logic ins;
   logic shl;
   logic [MaxAttrs-1:0] ge;
   logic out_valid_ff, out_valid_in;
   logic [IdxW-1:0] o_idx_ff, o_idx_in;
   logic [ConfW-1:0] o_conf_ff, o_conf_in;
   logic o_ev_ff, o_ev_in, o_ovf_ff, o_ovf_in, o_last_ff, o_last_in;
   logic slot_free;

   assign slot_free = !out_valid_ff || rsp_pop;

   always_comb begin
      for (int i = 0; i < MaxAttrs; i++)
         ge[i] = (CntW'(i) < count_ff) && (conf_ff[i] >= q_data.conf);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_in = rd_ff;
      ovf_in = ovf_ff;
      q_pop = 1'b0;
      ins = 1'b0;
      shl = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      o_idx_in = o_idx_ff;
      o_conf_in = o_conf_ff;
      o_ev_in = o_ev_ff;
      o_ovf_in = o_ovf_ff;
      o_last_in = o_last_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               ins = q_data.keep && (count_ff < CntW'(MaxAttrs));
               if (ins) count_in = count_ff + 1'b1;
               if (q_data.drop) ovf_in = 1'b1;
               if (q_data.last) begin
                  state_in = ST_EMIT;
                  rd_in = '0;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               o_ovf_in = ovf_ff;
               if (count_ff == '0) begin
                  o_idx_in = '0;
                  o_conf_in = '0;
                  o_ev_in = 1'b0;
                  o_last_in = 1'b1;
               end else begin
                  o_idx_in = idx_ff[0];
                  o_conf_in = conf_ff[0];
                  o_ev_in = 1'b1;
                  o_last_in = (rd_ff + 1'b1 == count_ff);
                  shl = 1'b1;
               end
               rd_in = rd_ff + 1'b1;
               if (o_last_in) begin
                  state_in = ST_COLLECT;
                  count_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         rd_ff <= '0;
         ovf_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_ff <= rd_in;
         ovf_ff <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      o_idx_ff <= o_idx_in;
      o_conf_ff <= o_conf_in;
      o_ev_ff <= o_ev_in;
      o_ovf_ff <= o_ovf_in;
      o_last_ff <= o_last_in;
      if (ins) begin
         for (int i = 0; i < MaxAttrs; i++) begin
            if (!ge[i]) begin
               if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
                  idx_ff[i] <= q_data.index;
                  conf_ff[i] <= q_data.conf;
               end else begin
                  idx_ff[i] <= idx_ff[(i == 0) ? 0 : i-1];
                  conf_ff[i] <= conf_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
      end else if (shl) begin
         for (int i = 0; i < MaxAttrs - 1; i++) begin
            idx_ff[i] <= idx_ff[i+1];
            conf_ff[i] <= conf_ff[i+1];
         end
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_attr_index = o_idx_ff;
   assign rsp_confidence = o_conf_ff;
   assign rsp_entry_valid = o_ev_ff;
   assign rsp_overflow = o_ovf_ff;
   assign rsp_last_result = o_last_ff;
endmodule

[hw/rtl/attribute_score_filter_sort.sv]
`timescale 1ns / 1ps
// Results leave the row after the set's last request, one per cycle while they are popped.
// Throughput: one request per cycle while full is low, into a parallel insertion row of 64
// cells; the row takes no requests while a set's results are delivered (one result for an
// empty set), and the queue ahead of it holds up to three requests meanwhile.
// Reset: synchronous, active high; clears counts, queue and valid flags, loads CSR defaults;
// the row holds garbage until written.
module attribute_score_filter_sort import asfs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic signed [15:0]  req_logit_neg,
   input  logic signed [15:0]  req_logit_pos,
   input  logic                req_last_attr,
   output logic                empty,
   input  logic                pop,
   output logic [IdxW-1:0]     rsp_attr_index,
   output logic [ConfW-1:0]    rsp_confidence,
   output logic                rsp_entry_valid,
   output logic                rsp_overflow,
   output logic                rsp_last_result,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [15:0]         csr_data
);
   logic [ConfW-1:0] thr_ff;
   logic pair_ff;
   logic f_valid, q_empty, q_pop, q_af;
   work_type f_work, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         pair_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_ff <= csr_data;
            CSR_PAIR_MODE: pair_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign full = q_af;

   asfs_front u_front (
      .clock(clock), .reset(reset), .in_valid(push && !full),
      .logit_neg(req_logit_neg), .logit_pos(req_logit_pos), .last_attr(req_last_attr),
      .threshold(thr_ff), .pair_mode(pair_ff), .out_valid(f_valid), .out_work(f_work)
   );

   asfs_fifo u_fifo (
      .clock(clock), .reset(reset), .wr_en(f_valid), .wr_data(f_work),
      .rd_en(q_pop), .rd_data(q_data), .empty(q_empty), .almost_full(q_af)
   );

   asfs_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
      .rsp_pop(pop), .rsp_empty(empty), .rsp_attr_index(rsp_attr_index),
      .rsp_confidence(rsp_confidence), .rsp_entry_valid(rsp_entry_valid),
      .rsp_overflow(rsp_overflow), .rsp_last_result(rsp_last_result)
   );
endmodule
